// ===== hdl/lcdw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdw_pkg
// Types, codes and constants shared by the character LCD bus writer.
// ----------------------------------------------------------------------------
package lcdw_pkg;

	localparam int LCDW_QUEUE_DEPTH = 4;

	localparam logic [2:0] OP_CMD  = 3'd0;
	localparam logic [2:0] OP_DATA = 3'd1;
	localparam logic [2:0] OP_INIT = 3'd2;
	localparam logic [2:0] OP_GOTO = 3'd3;
	localparam logic [2:0] OP_NUM2 = 3'd4;
	localparam logic [2:0] OP_NUM4 = 3'd5;

	localparam logic [1:0] ACT_BYTE  = 2'd0;
	localparam logic [1:0] ACT_POWER = 2'd1;
	localparam logic [1:0] ACT_DELAY = 2'd2;

	localparam logic [1:0] REG_NIBBLE_MODE = 2'd0;
	localparam logic [1:0] REG_WAIT_US     = 2'd1;
	localparam logic [1:0] REG_PULSE_US    = 2'd2;

	localparam logic       RST_NIBBLE_MODE = 1'b0;
	localparam logic [7:0] RST_WAIT_US     = 8'd40;
	localparam logic [3:0] RST_PULSE_US    = 4'd2;

	localparam logic [7:0]  CMD_FUNC_8BIT = 8'h38;
	localparam logic [7:0]  CMD_FUNC_4BIT = 8'h28;
	localparam logic [7:0]  CMD_DISP_ON   = 8'h0C;
	localparam logic [7:0]  CMD_CLEAR     = 8'h01;
	localparam logic [7:0]  CMD_ENTRY     = 8'h06;
	localparam logic [7:0]  CMD_SET_DDRAM = 8'h80;
	localparam logic [3:0]  ASCII_ZERO_HI = 4'h3;
	localparam logic [15:0] HOLD_POWER_US = 16'd40000;
	localparam logic [15:0] HOLD_DELAY_US = 16'd2000;
	localparam logic [7:0]  POWER_DATA_8  = 8'hFF;
	localparam logic [7:0]  POWER_DATA_4  = 8'hF0;
	localparam logic [15:0] RECIP_TEN     = 16'hCCCD;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  byte_value;
		logic [15:0] number;
		logic [6:0]  col;
		logic [7:0]  row;
	} req_t;

	typedef struct packed {
		logic        rs_pin;
		logic        rw_pin;
		logic        en_pin;
		logic [7:0]  data_pins;
		logic [15:0] hold_us;
		logic        last;
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       rs;
		logic [7:0] value;
		logic       last;
	} act_t;

	function automatic logic [7:0] line_offset(input logic [1:0] row);
		logic [7:0] off;
		case (row)
			2'd0: off = 8'h00;
			2'd1: off = 8'h40;
			2'd2: off = 8'h14;
			default: off = 8'h54;
		endcase
		return off;
	endfunction

endpackage

// ===== hdl/char_lcd_bus_writer_core.sv =====
// ----------------------------------------------------------------------------
// char_lcd_bus_writer_core
// Character LCD write bus driver: turns requests into timed pin phases.
//
// Channel   Direction  Handshake               Content
// req       in         req_valid/req_ready     op, byte, number, col, row
// phase     out        phase_valid/phase_ready rs, rw, en, data, hold, last
// APB       in/out     psel/penable/pready     nibble_mode, wait_us, pulse_us
//
// The back end issues one phase per cycle while phase_ready is high: a byte
// write is 3 phases on an 8-bit bus and 5 on a 4-bit bus, init is 14 or 22.
// Number requests form each digit in the front end's multiplier (a multiply
// step, then a digit store) before their bytes enter the queue; this overlaps
// earlier back end work. A request with no phases is taken, leaving no trace.
// Reset clears the bus levels to zero and the registers to their defaults.
// A stalled output holds its phase while the queue keeps filling.
// ----------------------------------------------------------------------------
module char_lcd_bus_writer_core #(
	parameter int QUEUE_DEPTH = lcdw_pkg::LCDW_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  lcdw_pkg::req_t   req,
	output logic             phase_valid,
	input  logic             phase_ready,
	output lcdw_pkg::phase_t phase,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import lcdw_pkg::*;

	logic       nibble_mode_q;
	logic [7:0] wait_us_q;
	logic [3:0] pulse_us_q;
	logic       cfg_wr;
	logic       push;
	logic       push_ready;
	act_t       push_data;
	logic       pop_valid;
	logic       pop_ready;
	act_t       pop_data;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nibble_mode_q <= RST_NIBBLE_MODE;
			wait_us_q     <= RST_WAIT_US;
			pulse_us_q    <= RST_PULSE_US;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_NIBBLE_MODE: nibble_mode_q <= pwdata[0];
				REG_WAIT_US:     wait_us_q     <= pwdata[7:0];
				REG_PULSE_US:    pulse_us_q    <= pwdata[3:0];
				default: nibble_mode_q <= nibble_mode_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_NIBBLE_MODE: prdata = {31'h0, nibble_mode_q};
			REG_WAIT_US:     prdata = {24'h0, wait_us_q};
			REG_PULSE_US:    prdata = {28'h0, pulse_us_q};
			default: prdata = '0;
		endcase
	end

	lcdw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.nibble_mode (nibble_mode_q),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.push        (push),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	lcdw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push),
		.wr_ready (push_ready),
		.wr_data  (push_data),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_data)
	);

	lcdw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.nibble_mode (nibble_mode_q),
		.wait_us     (wait_us_q),
		.pulse_us    (pulse_us_q),
		.act_valid   (pop_valid),
		.act_ready   (pop_ready),
		.act_in      (pop_data),
		.phase_valid (phase_valid),
		.phase_ready (phase_ready),
		.phase       (phase)
	);

endmodule

// ===== hdl/lcdw_front.sv =====
// ----------------------------------------------------------------------------
// lcdw_front
// Accepts requests, converts numbers to decimal digits and issues the
// request as a list of byte writes and fixed phases into the queue.
// ----------------------------------------------------------------------------
module lcdw_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          nibble_mode,
	input  logic          req_valid,
	output logic          req_ready,
	input  lcdw_pkg::req_t req,
	output logic          push,
	input  logic          push_ready,
	output lcdw_pkg::act_t push_data
);
	import lcdw_pkg::*;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_CONV = 2'd1;
	localparam logic [1:0] F_EMIT = 2'd2;

	logic [1:0]  state_q;
	logic [2:0]  op_q;
	logic [7:0]  val_q;
	logic [15:0] num_q;
	logic [31:0] prod_q;
	logic        phase_q;
	logic [1:0]  k_q;
	logic [2:0]  step_q;
	logic [3:0]  dig_q [4];

	logic        accept;
	logic [1:0]  last_dig;
	logic [2:0]  last_step;
	logic [1:0]  dig_idx;
	logic [12:0] quot;
	logic [15:0] rem;
	logic [7:0]  goto_byte;
	act_t        act;

	assign last_dig  = (op_q == OP_NUM4) ? 2'd3 : 2'd1;
	assign dig_idx   = last_dig - step_q[1:0];
	assign quot      = prod_q[31:19];
	assign rem       = num_q - {quot, 3'b000} - {2'b00, quot, 1'b0};
	assign goto_byte = (line_offset(req.row[1:0]) + {1'b0, req.col}) | CMD_SET_DDRAM;

	always_comb begin
		case (op_q)
			OP_INIT: last_step = 3'd5;
			OP_NUM2: last_step = 3'd1;
			OP_NUM4: last_step = 3'd3;
			default: last_step = 3'd0;
		endcase
	end

	always_comb begin
		act.kind  = ACT_BYTE;
		act.rs    = 1'b0;
		act.value = val_q;
		act.last  = (step_q == last_step);
		case (op_q)
			OP_DATA: act.rs = 1'b1;
			OP_INIT: begin
				case (step_q)
					3'd0: act.kind = ACT_POWER;
					3'd1: act.value = nibble_mode ? CMD_FUNC_4BIT : CMD_FUNC_8BIT;
					3'd2: act.value = CMD_DISP_ON;
					3'd3: act.value = CMD_CLEAR;
					3'd4: act.kind = ACT_DELAY;
					default: act.value = CMD_ENTRY;
				endcase
			end
			OP_NUM2, OP_NUM4: begin
				act.rs    = 1'b1;
				act.value = {ASCII_ZERO_HI, dig_q[dig_idx]};
			end
			default: act.rs = 1'b0;
		endcase
	end

	assign push      = (state_q == F_EMIT);
	assign push_data = act;
	assign req_ready = (state_q == F_IDLE) || (push && push_ready && act.last);
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
			phase_q <= 1'b0;
			k_q     <= '0;
		end else if (accept) begin
			step_q  <= '0;
			phase_q <= 1'b0;
			k_q     <= '0;
			case (req.op)
				OP_CMD, OP_DATA, OP_INIT: state_q <= F_EMIT;
				OP_GOTO: state_q <= (req.row[7:2] == '0) ? F_EMIT : F_IDLE;
				OP_NUM2, OP_NUM4: state_q <= F_CONV;
				default: state_q <= F_IDLE;
			endcase
		end else begin
			case (state_q)
				F_CONV: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						k_q <= k_q + 2'd1;
						if (k_q == last_dig) begin
							state_q <= F_EMIT;
						end
					end
				end
				F_EMIT: begin
					if (push_ready) begin
						if (act.last) begin
							state_q <= F_IDLE;
						end else begin
							step_q <= step_q + 3'd1;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.op;
			num_q <= req.number;
			val_q <= (req.op == OP_GOTO) ? goto_byte : req.byte_value;
		end else if (state_q == F_CONV) begin
			if (!phase_q) begin
				prod_q <= {16'h0000, num_q} * {16'h0000, RECIP_TEN};
			end else begin
				dig_q[k_q] <= rem[3:0];
				num_q      <= {3'b000, quot};
			end
		end
	end

endmodule

// ===== hdl/lcdw_fifo.sv =====
// ----------------------------------------------------------------------------
// lcdw_fifo
// Short queue of byte writes and fixed phases between front and back.
// ----------------------------------------------------------------------------
module lcdw_fifo #(
	parameter int DEPTH = lcdw_pkg::LCDW_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  lcdw_pkg::act_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output lcdw_pkg::act_t rd_data
);
	import lcdw_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	act_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign wr_ready = (cnt_q != CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hdl/lcdw_back.sv =====
// ----------------------------------------------------------------------------
// lcdw_back
// Expands queued byte writes into timed pin phases, tracks the bus levels
// and holds each phase in an output register until it is taken.
// ----------------------------------------------------------------------------
module lcdw_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            nibble_mode,
	input  logic [7:0]      wait_us,
	input  logic [3:0]      pulse_us,
	input  logic            act_valid,
	output logic            act_ready,
	input  lcdw_pkg::act_t  act_in,
	output logic            phase_valid,
	input  logic            phase_ready,
	output lcdw_pkg::phase_t phase
);
	import lcdw_pkg::*;

	act_t       act_q;
	logic       busy_q;
	logic [2:0] step_q;
	logic       rs_q;
	logic       en_q;
	logic [7:0] data_q;
	logic       out_valid_q;
	phase_t     out_q;

	logic       advance;
	logic       final_step;
	logic       next_rs;
	phase_t     ph;

	assign advance    = busy_q && (!out_valid_q || phase_ready);
	assign final_step = (act_q.kind != ACT_BYTE) || (step_q == (nibble_mode ? 3'd4 : 3'd2));
	assign act_ready  = !busy_q || (advance && final_step);

	always_comb begin
		ph.rs_pin    = act_q.rs;
		ph.rw_pin    = 1'b0;
		ph.en_pin    = 1'b0;
		ph.data_pins = data_q;
		ph.hold_us   = '0;
		ph.last      = act_q.last && final_step;
		next_rs      = act_q.rs;
		case (act_q.kind)
			ACT_POWER: begin
				ph.rs_pin    = 1'b1;
				ph.en_pin    = 1'b1;
				ph.data_pins = nibble_mode ? POWER_DATA_4 : POWER_DATA_8;
				ph.hold_us   = HOLD_POWER_US;
				next_rs      = 1'b1;
			end
			ACT_DELAY: begin
				ph.rs_pin  = rs_q;
				ph.en_pin  = en_q;
				ph.hold_us = HOLD_DELAY_US;
				next_rs    = rs_q;
			end
			default: begin
				case (step_q)
					3'd0: begin
						ph.rs_pin  = rs_q;
						ph.en_pin  = en_q;
						ph.hold_us = {8'h00, wait_us};
					end
					3'd1: begin
						ph.en_pin    = 1'b1;
						ph.data_pins = nibble_mode ? {act_q.value[7:4], 4'h0} : act_q.value;
						ph.hold_us   = {12'h000, pulse_us};
					end
					3'd3: begin
						ph.en_pin    = 1'b1;
						ph.data_pins = {act_q.value[3:0], 4'h0};
						ph.hold_us   = {12'h000, pulse_us};
					end
					default: ph.en_pin = 1'b0;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			rs_q        <= 1'b0;
			en_q        <= 1'b0;
			data_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (act_valid && act_ready) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (advance && final_step) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				step_q <= step_q + 3'd1;
			end
			if (advance) begin
				rs_q        <= next_rs;
				en_q        <= ph.en_pin;
				data_q      <= ph.data_pins;
				out_valid_q <= 1'b1;
			end else if (phase_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act_valid && act_ready) begin
			act_q <= act_in;
		end
		if (advance) begin
			out_q <= ph;
		end
	end

	assign phase_valid = out_valid_q;
	assign phase       = out_q;

endmodule

// ===== hdl/lcdw_checker.sv =====
// ----------------------------------------------------------------------------
// lcdw_checker
// Port-level checks on the LCD bus writer, bound to the top level.
// ----------------------------------------------------------------------------
module lcdw_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             phase_valid,
	input logic             phase_ready,
	input lcdw_pkg::phase_t phase,
	input logic             psel,
	input logic             pready
);

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid && !phase_ready |=> phase_valid && $stable(phase))
		else $error("phase changed while stalled");

	a_write_only: assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid |-> !phase.rw_pin)
		else $error("rw level high on a write phase");

	a_last_en_low: assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid && phase.last |-> !phase.en_pin && phase.hold_us == 16'h0000)
		else $error("request did not end on an enable-low phase");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("pready low during a transfer");

endmodule

bind char_lcd_bus_writer_core lcdw_checker u_lcdw_checker (.*);
